>>> hw/rtl/token_scanner_with_quotes_comments_assert.svh
// assertion macros for the checker file
`ifndef TOKEN_SCANNER_WITH_QUOTES_COMMENTS_ASSERT_SVH
`define TOKEN_SCANNER_WITH_QUOTES_COMMENTS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsq: same-cycle check failed");

// next-cycle implication, checked outside reset
`define TSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsq: next-cycle check failed");

`endif

>>> hw/rtl/tsq_pkg.sv
package tsq_pkg;

	localparam int SET_SIZE  = 8;
	localparam int POS_WIDTH = 32;
	localparam int CHARS_W   = 64;
	localparam int COUNT_W   = 4;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_POS_W = 32;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEARCH_MODE   = 3'd0,
		REG_TOKEN_CHARS   = 3'd1,
		REG_TOKEN_COUNT   = 3'd2,
		REG_COMMENT_CHARS = 3'd3,
		REG_COMMENT_COUNT = 3'd4,
		REG_ESCAPE_CHARS  = 3'd5,
		REG_ESCAPE_COUNT  = 3'd6,
		REG_UNUSED        = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_FOUND      = 2'd0,
		ST_INCOMPLETE = 2'd1,
		ST_OVERFLOW   = 2'd2,
		ST_RSVD       = 2'd3
	} status_t;

	// one classified byte on its way from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       esc;     // opens a quote
		logic       cmt;     // comment-start byte
		logic       fin;     // ends the search when checked plainly
		logic       mode;    // token mode at classification time
	} tsq_item_t;

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// entries at or beyond count do not match; counts above SET_SIZE cap naturally
	function automatic logic in_set(logic [CHARS_W-1:0] chars, logic [COUNT_W-1:0] count,
		logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < SET_SIZE; k++) begin
			if ((COUNT_W'(k) < count) && (chars[8*k +: 8] == c)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

>>> hw/rtl/tsq_front.sv
module tsq_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsq_pkg::CHARS_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tlast,
	input  logic                          s_tuser,
	input  logic                          q_full,
	output logic                          push,
	output tsq_pkg::tsq_item_t            push_item
);
	import tsq_pkg::*;

	logic                search_mode_q;
	logic [CHARS_W-1:0]  token_chars_q;
	logic [COUNT_W-1:0]  token_count_q;
	logic [CHARS_W-1:0]  comment_chars_q;
	logic [COUNT_W-1:0]  comment_count_q;
	logic [CHARS_W-1:0]  escape_chars_q;
	logic [COUNT_W-1:0]  escape_count_q;
	logic                tok_hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_mode_q   <= 1'b0;
			token_chars_q   <= '0;
			token_count_q   <= '0;
			comment_chars_q <= '0;
			comment_count_q <= '0;
			escape_chars_q  <= '0;
			escape_count_q  <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SEARCH_MODE:   search_mode_q   <= cfg_data[0];
				REG_TOKEN_CHARS:   token_chars_q   <= cfg_data;
				REG_TOKEN_COUNT:   token_count_q   <= cfg_data[COUNT_W-1:0];
				REG_COMMENT_CHARS: comment_chars_q <= cfg_data;
				REG_COMMENT_COUNT: comment_count_q <= cfg_data[COUNT_W-1:0];
				REG_ESCAPE_CHARS:  escape_chars_q  <= cfg_data;
				REG_ESCAPE_COUNT:  escape_count_q  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;
	assign tok_hit  = in_set(token_chars_q, token_count_q, s_tdata);

	always_comb begin
		push_item.data  = s_tdata;
		push_item.first = s_tuser;
		push_item.last  = s_tlast;
		push_item.esc   = in_set(escape_chars_q, escape_count_q, s_tdata);
		push_item.cmt   = in_set(comment_chars_q, comment_count_q, s_tdata);
		push_item.fin   = search_mode_q ? tok_hit : !is_ws(s_tdata);
		push_item.mode  = search_mode_q;
	end

endmodule

>>> hw/rtl/tsq_fifo.sv
module tsq_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tsq_pkg::tsq_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output tsq_pkg::tsq_item_t pop_item
);
	import tsq_pkg::*;

	tsq_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/tsq_back.sv
module tsq_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  tsq_pkg::tsq_item_t    q_item,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [tsq_pkg::OUT_POS_W-1:0] m_tdata,
	output logic [1:0]            m_tuser
);
	import tsq_pkg::*;

	logic                 in_quote_q;
	logic [7:0]           quote_byte_q;
	logic [7:0]           prev_byte_q;
	logic                 in_comment_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic                 done_q;

	logic                 cur_quote;
	logic [7:0]           cur_qbyte;
	logic [7:0]           cur_prev;
	logic                 cur_comment;
	logic [POS_WIDTH-1:0] cur_pos;
	logic                 cur_done;

	logic                 quote_d;
	logic [7:0]           qbyte_d;
	logic [7:0]           prev_d;
	logic                 comment_d;
	logic [POS_WIDTH-1:0] pos_d;
	logic                 done_d;
	logic                 found;
	logic                 res_valid;
	status_t              res_status;
	logic [OUT_POS_W-1:0] res_pos;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [OUT_POS_W-1:0] out_pos_q;

	assign pop = q_valid && (!out_valid_q || m_tready);

	// a first byte sees the cleared scan state
	always_comb begin
		cur_quote   = q_item.first ? 1'b0     : in_quote_q;
		cur_qbyte   = q_item.first ? 8'h00    : quote_byte_q;
		cur_prev    = q_item.first ? CH_SPACE : prev_byte_q;
		cur_comment = q_item.first ? 1'b0     : in_comment_q;
		cur_pos     = q_item.first ? '0       : pos_q;
		cur_done    = q_item.first ? 1'b0     : done_q;
	end

	always_comb begin
		quote_d    = cur_quote;
		qbyte_d    = cur_qbyte;
		prev_d     = cur_prev;
		comment_d  = cur_comment;
		pos_d      = cur_pos;
		done_d     = cur_done;
		found      = 1'b0;
		res_valid  = 1'b0;
		res_status = ST_FOUND;
		res_pos    = '0;
		if (!cur_done) begin
			if (&cur_pos) begin
				done_d     = 1'b1;
				res_valid  = 1'b1;
				res_status = ST_OVERFLOW;
				res_pos    = OUT_POS_W'(cur_pos);
			end else begin
				pos_d = cur_pos + 1'b1;
				priority if (cur_comment) begin
					if (q_item.data == CH_NEWLINE) begin
						comment_d = 1'b0;
						found     = q_item.fin;
						if (!q_item.fin) begin
							prev_d = q_item.data;
						end
					end
				end else if (cur_quote) begin
					if (q_item.data == cur_qbyte && cur_prev != CH_BACKSLASH) begin
						quote_d = 1'b0;
					end
					prev_d = q_item.data;
				end else if (q_item.esc) begin
					quote_d = 1'b1;
					qbyte_d = q_item.data;
				end else if (q_item.cmt && is_ws(cur_prev)) begin
					if (q_item.mode) begin
						found = 1'b1;
					end else begin
						comment_d = 1'b1;
					end
				end else begin
					found = q_item.fin;
					if (!q_item.fin) begin
						prev_d = q_item.data;
					end
				end
				if (found) begin
					done_d     = 1'b1;
					res_valid  = 1'b1;
					res_status = ST_FOUND;
					res_pos    = OUT_POS_W'(cur_pos);
				end else if (q_item.last) begin
					done_d     = 1'b1;
					res_valid  = 1'b1;
					res_status = ST_INCOMPLETE;
					res_pos    = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q   <= 1'b0;
			quote_byte_q <= 8'h00;
			prev_byte_q  <= CH_SPACE;
			in_comment_q <= 1'b0;
			pos_q        <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				in_quote_q   <= quote_d;
				quote_byte_q <= qbyte_d;
				prev_byte_q  <= prev_d;
				in_comment_q <= comment_d;
				pos_q        <= pos_d;
				done_q       <= done_d;
			end
			if (pop && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_status_q <= res_status;
			out_pos_q    <= res_pos;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pos_q;
	assign m_tuser  = out_status_q;

endmodule

>>> hw/rtl/token_scanner_with_quotes_comments.sv
// channel | dir | handshake          | contents
// cfg     | in  | cfg_valid/ready    | cfg_index register number, cfg_data value
// s       | in  | s_tvalid/s_tready  | tdata byte, tuser first_of_search, tlast last_of_data
// m       | out | m_tvalid/m_tready  | tdata position, tuser status
//
// one byte per cycle sustained while the queue has room; a result passes the queue and then the result register
// the front classifies a byte against all three sets in the cycle it is taken
// the back runs quote, comment and position state once per popped byte
// reset clears the registers and scan state at once, no clearing pass
// a 4-entry queue absorbs output stalls; s_tready drops only when it is full
module token_scanner_with_quotes_comments (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tsq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsq_pkg::CHARS_W-1:0]   cfg_data,
	// byte stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,   // last_of_data
	input  logic                          s_tuser,   // [0] first_of_search
	// search result out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tsq_pkg::OUT_POS_W-1:0] m_tdata,   // [31:0] position
	output logic [1:0]                    m_tuser    // [1:0] status
);
	import tsq_pkg::*;

	// classified byte handed from front to queue
	logic      push;
	tsq_item_t push_item;
	logic      q_full;

	// queue head seen by the back
	logic      pop;
	logic      q_valid;
	tsq_item_t q_item;

	// front: config registers and set compares
	tsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue between classification and scan state
	tsq_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_item  (q_item)
	);

	// back: quote/comment tracking, position count, result register
	tsq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> hw/rtl/tsq_checker.sv
`include "token_scanner_with_quotes_comments_assert.svh"

module tsq_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tready,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [tsq_pkg::OUT_POS_W-1:0] m_tdata,
	input  logic [1:0]                    m_tuser
);
	import tsq_pkg::*;

	logic out_stall;

	assign out_stall = m_tvalid && !m_tready;

	// stalled result beat holds
	`TSQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable({m_tuser, m_tdata}))

	// no reserved status code on a result
	`TSQ_ASSERT_NOW(a_status_code, clk, arst_n, m_tvalid, m_tuser != ST_RSVD)

	// data-ended result carries position zero
	`TSQ_ASSERT_NOW(a_incomplete_pos, clk, arst_n, m_tvalid && m_tuser == ST_INCOMPLETE, m_tdata == '0)

	// input backs up only behind a held result
	`TSQ_ASSERT_NOW(a_in_stall_cause, clk, arst_n, !s_tready, m_tvalid)

endmodule

bind token_scanner_with_quotes_comments tsq_checker u_tsq_checker (.*);

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsq_pkg::*;

	// stimulus sizing
	localparam int unsigned PHASE_ITEMS    = 220;
	localparam int unsigned PRESSURE_ITEMS = 80;
	localparam int unsigned HOLD_CYCLES    = 300;
	// a result passes the queue and then the result register after its beat, so this covers the pipe
	localparam int unsigned DRAIN_CYCLES   = 8;
	localparam int unsigned PRINT_CAP      = 40;

	// one byte of the scanned stream plus its framing flags
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} stream_byte_t;

	// one search outcome as the block should report it
	typedef struct packed {
		status_t     status;
		logic [31:0] position;
	} scan_report_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// configuration write channel
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	reg_idx_t    cfg_index = REG_SEARCH_MODE;
	logic [63:0] cfg_data  = '0;

	// byte stream in
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;   // [7:0] data_byte
	logic       s_tlast  = 1'b0; // last_of_data
	logic       s_tuser  = 1'b0; // [0] first_of_search

	// search result out
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] position
	logic [1:0]  m_tuser;        // [1:0] status

	// bytes waiting to be offered, and search outcomes waiting to arrive
	stream_byte_t byte_q[$];
	scan_report_t report_q[$];

	// idling knobs and the long receiver hold-off
	int unsigned src_gap_pct    = 0;
	int unsigned sink_stall_pct = 0;
	bit          hold_go        = 1'b0;
	logic        hold_off       = 1'b0;

	int unsigned err_count = 0;

	// register copies as the block should see them
	bit          token_mode = 1'b0;
	logic [63:0] tok_set    = '0;
	logic [3:0]  tok_n      = '0;
	logic [63:0] cmt_set    = '0;
	logic [3:0]  cmt_n      = '0;
	logic [63:0] esc_set    = '0;
	logic [3:0]  esc_n      = '0;

	// scan state, starting at its reset values
	bit          quoting     = 1'b0;
	logic [7:0]  quote_ch    = '0;
	logic [7:0]  prev_ch     = CH_SPACE;
	bit          commenting  = 1'b0;
	logic [31:0] next_pos    = '0;
	bit          search_over = 1'b0;

	token_scanner_with_quotes_comments u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// whitespace is space plus tab through carriage return
	function automatic bit blank_byte(logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// membership in a packed set; counts past eight use all eight lanes,
	// and zero bytes inside the count are real members
	function automatic bit set_hit(logic [63:0] chars, logic [3:0] n, logic [7:0] c);
		int lanes;
		lanes = (n > 4'd8) ? 8 : int'(n);
		for (int k = 0; k < lanes; k++) begin
			if (chars[8*k +: 8] == c) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// plain check of a byte outside quotes and comments
	function automatic bit plain_hit(logic [7:0] c);
		if (token_mode) begin
			return set_hit(tok_set, tok_n, c);
		end
		return !blank_byte(c);
	endfunction

	// advance the scan by one accepted beat and queue any outcome it causes
	function automatic void scan_byte(logic [7:0] c, logic first, logic last);
		bit           hit;
		scan_report_t rep;
		hit = 1'b0;
		if (first) begin
			quoting     = 1'b0;
			quote_ch    = '0;
			prev_ch     = CH_SPACE;
			commenting  = 1'b0;
			next_pos    = '0;
			search_over = 1'b0;
		end
		// a finished search ignores everything until a new start
		if (search_over) begin
			return;
		end
		rep.position = next_pos;
		// saturated counter ends the search on the next byte
		if (next_pos == '1) begin
			search_over = 1'b1;
			rep.status  = ST_OVERFLOW;
			report_q.push_back(rep);
			return;
		end
		next_pos = next_pos + 1;
		if (commenting) begin
			// only the newline leaves a comment, then it is checked plainly
			if (c == CH_NEWLINE) begin
				commenting = 1'b0;
				hit = plain_hit(c);
				if (!hit) begin
					prev_ch = c;
				end
			end
		end else if (quoting) begin
			// an escaped copy of the opening byte does not close the quote
			if (c == quote_ch && prev_ch != CH_BACKSLASH) begin
				quoting = 1'b0;
			end
			prev_ch = c;
		end else if (set_hit(esc_set, esc_n, c)) begin
			// opening byte leaves the previous byte alone
			quoting  = 1'b1;
			quote_ch = c;
		end else if (set_hit(cmt_set, cmt_n, c) && blank_byte(prev_ch)) begin
			// comment after whitespace: a find in token mode, a skip otherwise
			if (token_mode) begin
				hit = 1'b1;
			end else begin
				commenting = 1'b1;
			end
		end else begin
			hit = plain_hit(c);
			if (!hit) begin
				prev_ch = c;
			end
		end
		if (hit) begin
			search_over = 1'b1;
			rep.status  = ST_FOUND;
			report_q.push_back(rep);
		end else if (last) begin
			// data ran out first, position reads as zero
			search_over  = 1'b1;
			rep.status   = ST_INCOMPLETE;
			rep.position = '0;
			report_q.push_back(rep);
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_count++;
		if (err_count <= PRINT_CAP) begin
			$display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
		end
	endtask

	// sender: feeds byte_q onto the slave side, predicting on each beat
	always @(posedge clk or negedge arst_n) begin : drive
		stream_byte_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata, s_tuser, s_tlast);
			end
			if (!s_tvalid || s_tready) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
					nxt = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.data;
					s_tuser  <= nxt.first;
					s_tlast  <= nxt.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result beat against the oldest expected outcome
	always @(posedge clk or negedge arst_n) begin : watch
		scan_report_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (report_q.size() == 0) begin
					report_mismatch("result beat with nothing expected, position",
						m_tdata, '0);
				end else begin
					want = report_q.pop_front();
					if (m_tuser !== want.status) begin
						report_mismatch("status", 32'(m_tuser), 32'(want.status));
					end
					if (m_tdata !== want.position) begin
						report_mismatch("position", m_tdata, want.position);
					end
				end
			end
			m_tready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// long receiver hold-off so the output queue fills and s_tready drops
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic void push_byte(logic [7:0] d, bit f, bit l);
		byte_q.push_back('{data: d, first: f, last: l});
	endfunction

	// string as a byte run, start flag on the first and end flag on the final byte
	task automatic push_text(string s, bit opens, bit closes);
		for (int i = 0; i < s.len(); i++) begin
			push_byte(s[i], opens && i == 0, closes && i == s.len() - 1);
		end
	endtask

	// bytes biased toward whitespace, backslash and the configured sets
	function automatic logic [7:0] pick_byte();
		int unsigned k;
		k = $urandom_range(7);
		case ($urandom_range(9))
			0, 1: begin
				k = $urandom_range(5);
				return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
			end
			2: return CH_NEWLINE;
			3: return CH_BACKSLASH;
			4: return tok_set[8*k +: 8];
			5: return cmt_set[8*k +: 8];
			6: return esc_set[8*k +: 8];
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly well-formed searches, some long, a tenth with scrambled flags
	task automatic add_searches(int unsigned budget);
		int unsigned added;
		int unsigned len;
		bit          noisy;
		added = 0;
		while (added < budget) begin
			len   = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
			noisy = ($urandom_range(9) == 0);
			for (int i = 0; i < len; i++) begin
				if (noisy && i != len - 1) begin
					push_byte(pick_byte(), 1'($urandom_range(1)), $urandom_range(7) == 0);
				end else begin
					// the final byte always closes, so no search spans a register write
					push_byte(pick_byte(), !noisy && i == 0, i == len - 1);
				end
			end
			added += len;
		end
	endtask

	// wait until every byte is taken, every outcome seen, and the pipe is empty
	task automatic settle();
		while (byte_q.size() != 0 || s_tvalid) @(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SEARCH_MODE:   token_mode = val[0];
			REG_TOKEN_CHARS:   tok_set    = val;
			REG_TOKEN_COUNT:   tok_n      = val[3:0];
			REG_COMMENT_CHARS: cmt_set    = val;
			REG_COMMENT_COUNT: cmt_n      = val[3:0];
			REG_ESCAPE_CHARS:  esc_set    = val;
			REG_ESCAPE_COUNT:  esc_n      = val[3:0];
			default: ;
		endcase
	endtask

	task automatic load_sets(bit mode, logic [63:0] tok, logic [3:0] ntok,
		logic [63:0] cmt, logic [3:0] ncmt, logic [63:0] esc, logic [3:0] nesc);
		write_reg(REG_SEARCH_MODE, 64'(mode));
		write_reg(REG_TOKEN_CHARS, tok);
		write_reg(REG_TOKEN_COUNT, 64'(ntok));
		write_reg(REG_COMMENT_CHARS, cmt);
		write_reg(REG_COMMENT_COUNT, 64'(ncmt));
		write_reg(REG_ESCAPE_CHARS, esc);
		write_reg(REG_ESCAPE_COUNT, 64'(nesc));
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: visible mode, all sets empty
		// no start flag after reset, tab skipped, 'a' found
		push_text("\ta", 1'b0, 1'b0);
		push_byte(CH_CR, 1'b1, 1'b1);      // whitespace only, runs out
		push_byte(8'hFF, 1'b1, 1'b0);      // top byte value is visible
		push_byte(8'h00, 1'b1, 1'b1);      // so is zero
		settle();

		// token mode with ',' ';' and two zero lanes, '#' comments, two quote bytes
		load_sets(1'b1, 64'h3B2C, 4'd4, 64'h23, 4'd1, 64'h2722, 4'd2);
		// quoted tokens skipped, escaped quote does not close
		push_text("a\",\\\",\",", 1'b1, 1'b0);
		// comment byte after whitespace ends the search
		push_text(" #", 1'b1, 1'b0);
		// comment byte after a visible byte is plain; zero lane is a token
		push_text("x#", 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		settle();

		// visible mode: comment skipped up to the newline
		write_reg(REG_SEARCH_MODE, 64'(1'b0));
		push_text(" #a\nz", 1'b1, 1'b1);
		// data ends inside a quote, then inside a comment
		push_text("\"x", 1'b1, 1'b1);
		push_text("#x", 1'b1, 1'b1);
		settle();

		// stage one: sender gaps light, receiver stalls heavy
		src_gap_pct    = 22;
		sink_stall_pct = 54;
		load_sets(1'b0, {$urandom, $urandom}, 4'd3, 64'h3B23, 4'd2, 64'h2722, 4'd2);
		add_searches(PHASE_ITEMS);
		settle();
		load_sets(1'b1, 64'h3D3B_2C29_28, 4'd5, 64'h23, 4'd1, 64'h22, 4'd1);
		add_searches(PHASE_ITEMS);
		settle();

		// stage two: the other way round
		src_gap_pct    = 54;
		sink_stall_pct = 22;
		// token count at the top of the field, all-ones tokens, zero comment bytes
		load_sets(1'b1, '1, 4'd15, '0, 4'd8, '0, 4'd0);
		add_searches(PHASE_ITEMS);
		settle();
		// empty token set: only comment bytes after whitespace are found
		load_sets(1'b1, {$urandom, $urandom}, 4'd0, 64'h2F23, 4'd2, 64'h6022, 4'd2);
		add_searches(PHASE_ITEMS);
		settle();

		// stage three: no idling on either side
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		load_sets(1'b0, '0, 4'd0, {$urandom, $urandom}, 4'd15, {$urandom, $urandom}, 4'd8);
		add_searches(PHASE_ITEMS);
		settle();

		// one-byte searches while the receiver holds off: every beat gives a result
		hold_go = 1'b1;
		for (int i = 0; i < PRESSURE_ITEMS; i++) begin
			push_byte(pick_byte(), 1'b1, 1'b1);
		end
		settle();

		load_sets(1'b1, {$urandom, $urandom}, 4'($urandom_range(15)),
			{$urandom, $urandom}, 4'($urandom_range(15)),
			{$urandom, $urandom}, 4'($urandom_range(15)));
		add_searches(PHASE_ITEMS);
		settle();

		if (err_count == 0) begin
			$display("token_scanner_with_quotes_comments verification clean");
		end else begin
			$display("token_scanner_with_quotes_comments verification failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("token_scanner_with_quotes_comments verification failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_front.sv
hw/rtl/tsq_fifo.sv
hw/rtl/tsq_back.sv
hw/rtl/token_scanner_with_quotes_comments.sv
hw/rtl/tsq_checker.sv
tb/tb.sv
